/* hw/rtl/qsd_pkg.sv */
`timescale 1ns / 1ps

package qsd_pkg;

  localparam int LmsTaps      = 4;
  localparam int SliceSamples = 20;
  localparam int CntW         = 5;

  typedef enum logic [1:0] {
    OP_LOAD_HIST = 2'd0,
    OP_LOAD_WTS  = 2'd1,
    OP_DECODE    = 2'd2,
    OP_UNUSED    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic load_hist;
    logic load_wts;
    logic start;
    logic step;
  } lane_ctrl_t;

  localparam logic signed [15:0] DQ_TABLE [16][8] = '{
    '{16'sd1,    -16'sd1,    16'sd3,    -16'sd3,    16'sd5,    -16'sd5,    16'sd7,     -16'sd7},
    '{16'sd5,    -16'sd5,    16'sd18,   -16'sd18,   16'sd32,   -16'sd32,   16'sd49,    -16'sd49},
    '{16'sd16,   -16'sd16,   16'sd53,   -16'sd53,   16'sd95,   -16'sd95,   16'sd147,   -16'sd147},
    '{16'sd34,   -16'sd34,   16'sd113,  -16'sd113,  16'sd203,  -16'sd203,  16'sd315,   -16'sd315},
    '{16'sd63,   -16'sd63,   16'sd210,  -16'sd210,  16'sd378,  -16'sd378,  16'sd588,   -16'sd588},
    '{16'sd104,  -16'sd104,  16'sd345,  -16'sd345,  16'sd621,  -16'sd621,  16'sd966,   -16'sd966},
    '{16'sd158,  -16'sd158,  16'sd528,  -16'sd528,  16'sd950,  -16'sd950,  16'sd1477,  -16'sd1477},
    '{16'sd228,  -16'sd228,  16'sd760,  -16'sd760,  16'sd1368, -16'sd1368, 16'sd2128,  -16'sd2128},
    '{16'sd316,  -16'sd316,  16'sd1053, -16'sd1053, 16'sd1895, -16'sd1895, 16'sd2947,  -16'sd2947},
    '{16'sd422,  -16'sd422,  16'sd1405, -16'sd1405, 16'sd2529, -16'sd2529, 16'sd3934,  -16'sd3934},
    '{16'sd548,  -16'sd548,  16'sd1828, -16'sd1828, 16'sd3290, -16'sd3290, 16'sd5117,  -16'sd5117},
    '{16'sd696,  -16'sd696,  16'sd2320, -16'sd2320, 16'sd4176, -16'sd4176, 16'sd6496,  -16'sd6496},
    '{16'sd868,  -16'sd868,  16'sd2893, -16'sd2893, 16'sd5207, -16'sd5207, 16'sd8099,  -16'sd8099},
    '{16'sd1064, -16'sd1064, 16'sd3548, -16'sd3548, 16'sd6386, -16'sd6386, 16'sd9933,  -16'sd9933},
    '{16'sd1286, -16'sd1286, 16'sd4288, -16'sd4288, 16'sd7718, -16'sd7718, 16'sd12005, -16'sd12005},
    '{16'sd1536, -16'sd1536, 16'sd5120, -16'sd5120, 16'sd9216, -16'sd9216, 16'sd14336, -16'sd14336}
  };

  function automatic logic signed [15:0] dq_lookup(input logic [3:0] sf, input logic [2:0] code);
    return DQ_TABLE[sf][code];
  endfunction

endpackage

/* hw/rtl/qsd_lane.sv */
`timescale 1ns / 1ps

module qsd_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  qsd_pkg::lane_ctrl_t ctrl,
  input  logic [63:0]         word,
  output logic signed [15:0]  sample
);
  import qsd_pkg::*;

  logic signed [15:0] hist_r [LmsTaps];
  logic signed [31:0] wts_r  [LmsTaps];
  logic [63:0]        slice_r;

  logic signed [47:0] prod [LmsTaps];
  logic signed [49:0] acc;
  logic signed [36:0] pred;
  logic signed [15:0] resid;
  logic signed [37:0] total;
  logic signed [11:0] delta;

  always_comb begin
    acc = '0;
    for (int i = 0; i < LmsTaps; i++) begin
      prod[i] = wts_r[i] * hist_r[i];
      acc     = acc + 50'(prod[i]);
    end
    pred  = acc[49:13];
    resid = dq_lookup(slice_r[63:60], slice_r[59:57]);
    total = 38'(pred) + 38'(resid);
    if (total < -38'sd32768) begin
      sample = -16'sd32768;
    end else if (total > 38'sd32767) begin
      sample = 16'sd32767;
    end else begin
      sample = total[15:0];
    end
    delta = resid[15:4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LmsTaps; i++) begin
        hist_r[i] <= '0;
        wts_r[i]  <= '0;
      end
    end else if (ctrl.load_hist) begin
      for (int i = 0; i < LmsTaps; i++) begin
        hist_r[i] <= word[63 - 16 * i -: 16];
      end
    end else if (ctrl.load_wts) begin
      for (int i = 0; i < LmsTaps; i++) begin
        wts_r[i] <= 32'(signed'(word[63 - 16 * i -: 16]));
      end
    end else if (ctrl.step) begin
      for (int i = 0; i < LmsTaps; i++) begin
        if (hist_r[i] < 0) begin
          wts_r[i] <= wts_r[i] - 32'(delta);
        end else begin
          wts_r[i] <= wts_r[i] + 32'(delta);
        end
      end
      for (int i = 0; i < LmsTaps - 1; i++) begin
        hist_r[i] <= hist_r[i + 1];
      end
      hist_r[LmsTaps - 1] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      slice_r <= word;
    end else if (ctrl.step) begin
      slice_r <= {slice_r[63:60], slice_r[56:0], 3'b000};
    end
  end

endmodule

/* hw/rtl/qsd_merge.sv */
`timescale 1ns / 1ps

module qsd_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  input  logic               last_in,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic               out_last
);

  logic               valid_r;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;
  logic               last_r;

  assign free             = !valid_r || !out_stall;
  assign out_valid        = valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;
  assign out_last         = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step && free) begin
      left_r  <= left_in;
      right_r <= right_in;
      last_r  <= last_in;
    end
  end

endmodule

/* hw/rtl/qoa_stereo_slice_decoder_core.sv */
`timescale 1ns / 1ps
// A load item updates the predictor state of one channel.
// A decode item of n pairs runs one LMS recurrence per channel per cycle while the output is free,
// and holds in_stall until its last pair is stepped; each pair is presented from the merge output register.
// Output back-pressure holds the recurrence in place until the output register frees.
// Synchronous reset clears all history and weights to zero and empties the output.

module qoa_stereo_slice_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic               in_channel,
  input  logic [63:0]        in_left_word,
  input  logic [63:0]        in_right_word,
  input  logic [4:0]         in_sample_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic               out_last
);
  import qsd_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t          state_r;
  logic [CntW-1:0] remain_r;

  logic            accept;
  logic            free;
  logic            step;
  logic [CntW-1:0] count_sat;
  opcode_t         op;
  lane_ctrl_t      ctrl_l;
  lane_ctrl_t      ctrl_r;
  logic [63:0]     right_word;
  logic signed [15:0] left_s;
  logic signed [15:0] right_s;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign op        = opcode_t'(in_opcode);
  assign step      = (state_r == ST_RUN) && free;
  assign count_sat = (in_sample_count > CntW'(SliceSamples)) ? CntW'(SliceSamples)
                                                             : in_sample_count;

  // Load items carry their word on the left port for either channel.
  assign right_word = (op == OP_DECODE) ? in_right_word : in_left_word;

  always_comb begin
    ctrl_l.load_hist = accept && (op == OP_LOAD_HIST) && !in_channel;
    ctrl_l.load_wts  = accept && (op == OP_LOAD_WTS) && !in_channel;
    ctrl_l.start     = accept && (op == OP_DECODE);
    ctrl_l.step      = step;
    ctrl_r.load_hist = accept && (op == OP_LOAD_HIST) && in_channel;
    ctrl_r.load_wts  = accept && (op == OP_LOAD_WTS) && in_channel;
    ctrl_r.start     = ctrl_l.start;
    ctrl_r.step      = step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      remain_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (op == OP_DECODE) && (count_sat != '0)) begin
            state_r  <= ST_RUN;
            remain_r <= count_sat;
          end
        end
        ST_RUN: begin
          if (step) begin
            remain_r <= remain_r - 1'b1;
            if (remain_r == CntW'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  qsd_lane u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl_l),
    .word   (in_left_word),
    .sample (left_s)
  );

  qsd_lane u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl_r),
    .word   (right_word),
    .sample (right_s)
  );

  qsd_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .left_in          (left_s),
    .right_in         (right_s),
    .last_in          (remain_r == CntW'(1)),
    .free             (free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_last         (out_last)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import qsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 450;
  localparam int CHUNKS      = 8;
  localparam int NDIR        = 20;
  localparam int DRAIN       = 30;

  typedef struct packed {
    opcode_t            op;
    logic               ch;
    logic [63:0]        lw;
    logic [63:0]        rw;
    logic [4:0]         cnt;
    logic               typed;
    logic signed [15:0] tl;
    logic signed [15:0] tr;
  } stim_t;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] r;
    logic               last;
  } pcm_pair_t;

  // Typed rows repeat their pair on every position of the item.
  localparam stim_t DIR_TAB [NDIR] = '{
    '{OP_DECODE,    1'b0, 64'h0, 64'h0, 5'd1, 1'b1, 16'sd1, 16'sd1},
    '{OP_DECODE,    1'b1, 64'h0, 64'h0, 5'd0, 1'b0, 16'sd0, 16'sd0},
    '{OP_UNUSED,    1'b0, 64'hA5A5_5A5A_F00F_0FF0, 64'h5A5A_A5A5_0FF0_F00F, 5'd5,
      1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_HIST, 1'b0, 64'h7FFF_7FFF_7FFF_7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31,
      1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_WTS,  1'b0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h0, 5'd0, 1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_HIST, 1'b1, 64'h8000_8000_8000_8000, 64'h0, 5'd20, 1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_WTS,  1'b1, 64'h7FFF_7FFF_7FFF_7FFF, 64'h0, 5'd0, 1'b0, 16'sd0, 16'sd0},
    '{OP_DECODE,    1'b0, 64'h0, 64'h0, 5'd20, 1'b1, 16'sh7FFF, 16'sh8000},
    '{OP_DECODE,    1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hF000_0000_0000_0000, 5'd31,
      1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_WTS,  1'b0, 64'h8000_8000_8000_8000, 64'h0, 5'd1, 1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_WTS,  1'b1, 64'h8000_8000_8000_8000, 64'h0, 5'd1, 1'b0, 16'sd0, 16'sd0},
    '{OP_DECODE,    1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd21,
      1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_HIST, 1'b0, 64'h0001_FFFF_0003_FFFD, 64'h0, 5'd0, 1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_HIST, 1'b1, 64'hFFFF_0001_FFFD_0003, 64'hDEAD_BEEF_0BAD_F00D, 5'd7,
      1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_WTS,  1'b0, 64'h0000_0000_E000_4000, 64'h0, 5'd0, 1'b0, 16'sd0, 16'sd0},
    '{OP_LOAD_WTS,  1'b1, 64'h0000_0000_E000_4000, 64'h0, 5'd0, 1'b0, 16'sd0, 16'sd0},
    '{OP_DECODE,    1'b0, 64'h7123_4567_89AB_CDEF, 64'h8FED_CBA9_8765_4321, 5'd20,
      1'b0, 16'sd0, 16'sd0},
    '{OP_UNUSED,    1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd20,
      1'b0, 16'sd0, 16'sd0},
    '{OP_DECODE,    1'b1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 5'd19,
      1'b0, 16'sd0, 16'sd0},
    '{OP_DECODE,    1'b0, 64'hF249_2492_4924_9249, 64'h3DB6_DB6D_B6DB_6DB6, 5'd1,
      1'b0, 16'sd0, 16'sd0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_opcode = '0;
  logic               in_channel = 1'b0;
  logic [63:0]        in_left_word = '0;
  logic [63:0]        in_right_word = '0;
  logic [4:0]         in_sample_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_left_sample;
  logic signed [15:0] out_right_sample;
  logic               out_last;

  logic               cur_typed = 1'b0;
  logic signed [15:0] cur_tl = '0;
  logic signed [15:0] cur_tr = '0;

  logic signed [15:0] lms_hist_m [2*LmsTaps];
  logic [31:0]        lms_wts_m [2*LmsTaps];
  pcm_pair_t          pcm_q [$];

  int tx_pct = 0;
  int rx_pct = 0;
  int n_real = 0;
  int n_items = 0;
  int pairs_seen = 0;
  int errors = 0;
  int cycle_cnt = 0;

  qoa_stereo_slice_decoder_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_channel       (in_channel),
    .in_left_word     (in_left_word),
    .in_right_word    (in_right_word),
    .in_sample_count  (in_sample_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pairs outstanding", cycle_cnt, pcm_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
  end

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH @%0d: %s", cycle_cnt, msg);
  endtask

  function automatic logic [63:0] dq_row(input logic [3:0] sf);
    case (sf)
      4'd0:  return {16'd1,    16'd3,    16'd5,    16'd7};
      4'd1:  return {16'd5,    16'd18,   16'd32,   16'd49};
      4'd2:  return {16'd16,   16'd53,   16'd95,   16'd147};
      4'd3:  return {16'd34,   16'd113,  16'd203,  16'd315};
      4'd4:  return {16'd63,   16'd210,  16'd378,  16'd588};
      4'd5:  return {16'd104,  16'd345,  16'd621,  16'd966};
      4'd6:  return {16'd158,  16'd528,  16'd950,  16'd1477};
      4'd7:  return {16'd228,  16'd760,  16'd1368, 16'd2128};
      4'd8:  return {16'd316,  16'd1053, 16'd1895, 16'd2947};
      4'd9:  return {16'd422,  16'd1405, 16'd2529, 16'd3934};
      4'd10: return {16'd548,  16'd1828, 16'd3290, 16'd5117};
      4'd11: return {16'd696,  16'd2320, 16'd4176, 16'd6496};
      4'd12: return {16'd868,  16'd2893, 16'd5207, 16'd8099};
      4'd13: return {16'd1064, 16'd3548, 16'd6386, 16'd9933};
      4'd14: return {16'd1286, 16'd4288, 16'd7718, 16'd12005};
      default: return {16'd1536, 16'd5120, 16'd9216, 16'd14336};
    endcase
  endfunction

  function automatic int residual(input logic [3:0] sf, input logic [2:0] code);
    logic [63:0] row;
    int          mag;
    row = dq_row(sf);
    mag = int'(row[63 - 16*code[2:1] -: 16]);
    return code[0] ? -mag : mag;
  endfunction

  task automatic lms_step(input int ch, input logic [63:0] word, input int k,
                          output logic signed [15:0] smp);
    int          base;
    longint      acc;
    longint      s;
    int          r;
    int          d;
    logic [3:0]  sf;
    logic [2:0]  code;
    base = ch * LmsTaps;
    sf   = word[63:60];
    code = word[(59 - 3*k) -: 3];
    acc  = 0;
    for (int i = 0; i < LmsTaps; i++) begin
      acc += longint'($signed(lms_wts_m[base+i])) * longint'(lms_hist_m[base+i]);
    end
    r = residual(sf, code);
    s = (acc >>> 13) + r;
    if (s < -32768) s = -32768;
    if (s > 32767) s = 32767;
    d = r >>> 4;
    for (int i = 0; i < LmsTaps; i++) begin
      if (lms_hist_m[base+i] < 0) lms_wts_m[base+i] = lms_wts_m[base+i] - d;
      else lms_wts_m[base+i] = lms_wts_m[base+i] + d;
    end
    for (int i = 0; i < LmsTaps - 1; i++) begin
      lms_hist_m[base+i] = lms_hist_m[base+i+1];
    end
    lms_hist_m[base+LmsTaps-1] = s[15:0];
    smp = s[15:0];
  endtask

  task automatic predict_item(input logic [1:0] op, input logic ch, input logic [63:0] lw,
                              input logic [63:0] rw, input logic [4:0] cnt, input logic typed,
                              input logic signed [15:0] tl, input logic signed [15:0] tr);
    int                 n;
    logic [15:0]        v;
    logic signed [15:0] l;
    logic signed [15:0] r;
    n = (cnt > SliceSamples) ? SliceSamples : cnt;
    case (op)
      OP_LOAD_HIST, OP_LOAD_WTS: begin
        for (int i = 0; i < LmsTaps; i++) begin
          v = lw[63 - 16*i -: 16];
          if (op == OP_LOAD_HIST) lms_hist_m[ch*LmsTaps+i] = v;
          else lms_wts_m[ch*LmsTaps+i] = {{16{v[15]}}, v};
        end
      end
      OP_DECODE: begin
        for (int k = 0; k < n; k++) begin
          lms_step(0, lw, k, l);
          lms_step(1, rw, k, r);
          if (typed) pcm_q.push_back('{tl, tr, k + 1 == n});
          else pcm_q.push_back('{l, r, k + 1 == n});
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pcm_pair_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pcm_q.size() == 0) begin
          report($sformatf("unexpected pair L=%0d R=%0d last=%0b",
                           out_left_sample, out_right_sample, out_last));
        end else begin
          want = pcm_q.pop_front();
          if (out_left_sample !== want.l)
            report($sformatf("pair %0d left_sample got %0d expected %0d",
                             pairs_seen, out_left_sample, want.l));
          if (out_right_sample !== want.r)
            report($sformatf("pair %0d right_sample got %0d expected %0d",
                             pairs_seen, out_right_sample, want.r));
          if (out_last !== want.last)
            report($sformatf("pair %0d last got %0b expected %0b",
                             pairs_seen, out_last, want.last));
        end
        pairs_seen++;
      end
      if (in_valid && !in_stall) begin
        predict_item(in_opcode, in_channel, in_left_word, in_right_word, in_sample_count,
                     cur_typed, cur_tl, cur_tr);
        n_items++;
      end
    end
  end

  function automatic stim_t mk(input opcode_t op, input logic ch, input logic [63:0] lw,
                               input logic [63:0] rw, input logic [4:0] cnt);
    return '{op, ch, lw, rw, cnt, 1'b0, 16'sd0, 16'sd0};
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_lanes(input int kind);
    logic [63:0] w;
    case (kind)
      0: w = rand_word();
      1: begin
        for (int i = 0; i < LmsTaps; i++) begin
          w[63 - 16*i -: 16] = 16'($signed($urandom_range(0, 16383)) - 8192);
        end
      end
      default: w = 64'h0000_0000_E000_4000;
    endcase
    return w;
  endfunction

  task automatic set_phase(input int mode);
    case (mode)
      0: begin tx_pct = 0;  rx_pct = 0;  end
      1: begin tx_pct = 57; rx_pct = 0;  end
      2: begin tx_pct = 0;  rx_pct = 57; end
      default: begin tx_pct = 28; rx_pct = 28; end
    endcase
  endtask

  task automatic send(input stim_t s);
    if (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_pct);
    end
    in_valid        <= 1'b1;
    in_opcode       <= s.op;
    in_channel      <= s.ch;
    in_left_word    <= s.lw;
    in_right_word   <= s.rw;
    in_sample_count <= s.cnt;
    cur_typed       <= s.typed;
    cur_tl          <= s.tl;
    cur_tr          <= s.tr;
    do @(posedge clk); while (in_stall);
    if (s.op != OP_UNUSED) n_real++;
  endtask

  task automatic send_frame();
    int roll;
    if ($urandom_range(3) != 0) begin
      for (int ch = 0; ch < 2; ch++) begin
        send(mk(OP_LOAD_HIST, ch[0], rand_lanes($urandom_range(1)), rand_word(),
                5'($urandom)));
        send(mk(OP_LOAD_WTS, ch[0], rand_lanes($urandom_range(2)), rand_word(),
                5'($urandom)));
      end
    end
    repeat ($urandom_range(1, 6)) begin
      roll = $urandom_range(99);
      if (roll < 6)
        send(mk(OP_UNUSED, 1'($urandom_range(1)), rand_word(), rand_word(), 5'($urandom)));
      else if (roll < 10)
        send(mk(OP_DECODE, 1'($urandom_range(1)), rand_word(), rand_word(), 5'd0));
      else if (roll < 14)
        send(mk(OP_DECODE, 1'($urandom_range(1)), rand_word(), rand_word(),
                5'($urandom_range(21, 31))));
      else if (roll < 20)
        send(mk(opcode_t'($urandom_range(1)), 1'($urandom_range(1)), rand_word(),
                rand_word(), 5'($urandom)));
      else
        send(mk(OP_DECODE, 1'($urandom_range(1)), rand_word(), rand_word(),
                ($urandom_range(9) < 7) ? 5'd20 : 5'($urandom_range(1, 19))));
    end
  endtask

  initial begin
    for (int i = 0; i < 2*LmsTaps; i++) begin
      lms_hist_m[i] = '0;
      lms_wts_m[i]  = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_phase(0);
    for (int i = 0; i < NDIR; i++) begin
      send(DIR_TAB[i]);
    end
    for (int c = 0; c < CHUNKS; c++) begin
      set_phase(c % 4);
      while (n_real < (c + 1) * (ITEM_TARGET / CHUNKS)) begin
        send_frame();
      end
    end
    in_valid <= 1'b0;
    while (pcm_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (pcm_q.size() != 0) report($sformatf("%0d pairs never arrived", pcm_q.size()));
    $display("Ran %0d items (%0d load or decode) and checked %0d stereo pairs in %0d cycles,",
             n_items, n_real, pairs_seen, cycle_cnt);
    $display("under no idling, sender gaps, receiver stalls and both; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/qsd_pkg.sv
hw/rtl/qsd_lane.sv
hw/rtl/qsd_merge.sv
hw/rtl/qoa_stereo_slice_decoder_core.sv
verif/tb.sv
